// File: rtl/assert_macros.svh
// Assertion macros shared by the sieve RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/oss_pkg.sv
// Types and constants of the odd-only segmented sieve.
`timescale 1ns / 1ps

package oss_pkg;

   localparam int NUM_W   = 48;
   localparam int PRIME_W = 24;
   localparam int WORD_W  = 64;
   localparam int WIDX_W  = 8;
   localparam int OP_W    = 2;

   localparam logic [NUM_W-1:0] MIN_LOW = 48'd3;

   localparam logic [OP_W-1:0] OP_OPEN   = 2'd0;
   localparam logic [OP_W-1:0] OP_STRIKE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_OPEN  = 9'b000000010,
      ST_CLEAR = 9'b000000100,
      ST_SQ    = 9'b000001000,
      ST_CHK   = 9'b000010000,
      ST_DIV   = 9'b000100000,
      ST_ADJ   = 9'b001000000,
      ST_MARK  = 9'b010000000,
      ST_READ  = 9'b100000000
   } oss_state_type;

   typedef struct packed {
      logic               done;
      logic [PRIME_W-1:0] rem;
   } oss_rem_status_type;

endpackage

// File: rtl/oss_map_ram.sv
// Bitmap memory of struck odd numbers, one write and one registered read port.
`timescale 1ns / 1ps

module oss_map_ram import oss_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  logic [WORD_W-1:0] wdata,
   input  logic [AW-1:0]     raddr,
   output logic [WORD_W-1:0] rdata
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rdata_ff;

   // A read at the address being written returns the old word.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/oss_rem_unit.sv
// Restoring remainder unit: dividend modulo divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module oss_rem_unit import oss_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   dividend,
   input  logic [PRIME_W-1:0] divisor,
   output oss_rem_status_type status
);

   localparam int CW = $clog2(NUM_W);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [PRIME_W-1:0] rem_ff, rem_in;
   logic [PRIME_W-1:0] div_ff, div_in;
   logic [PRIME_W:0]   trial;
   logic [PRIME_W:0]   trial_sub;
   logic [PRIME_W-1:0] rem_step;

   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   // The trial value stays below twice the divisor, so one subtract suffices.
   assign rem_step  = (trial >= {1'b0, div_ff}) ? trial_sub[PRIME_W-1:0] : trial[PRIME_W-1:0];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_in    = num_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CW'(NUM_W - 1);
         num_in    = dividend;
         rem_in    = '0;
         div_in    = divisor;
      end else if (active_ff) begin
         rem_in = rem_step;
         num_in = {num_ff[NUM_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            cnt_in = cnt_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign status.done = done_ff;
   assign status.rem  = rem_ff;

   `ASSERT_CLK(a_rem_below_divisor, done_ff |-> (rem_ff < div_ff), "remainder not below divisor")
   `ASSERT_CLK(a_no_restart, start |-> !active_ff, "remainder unit restarted while active")

endmodule

// File: rtl/odd_only_segmented_prime_sieve_top.sv
// Top level of the odd-only segmented prime sieve.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Handshake              Payload
// req       start / busy           req_opcode, req_segment_start, req_base_prime,
//                                  req_word_index
// rsp       rsp_valid (strobe)     rsp_word_base, rsp_prime_flags, rsp_last_word
// csr       csr_valid / csr_ready  csr_upper_bound
//
// Opening a segment passes ST_OPEN, then ST_CLEAR clears the map one word per cycle.
// Striking prime p passes ST_SQ and ST_CHK, then ST_DIV for the remainder unit and ST_ADJ
// when p*p lies below the segment start, then ST_MARK strikes each multiple in turn and
// ends as the last map update is written. A read passes ST_READ; the result strobe is
// high in the first cycle with busy low. After reset the map is cleared while busy is high.
// Results cannot be stalled; csr_ready is always high.

module odd_only_segmented_prime_sieve_top import oss_pkg::*; #(
   parameter int ODDS_PER_SEGMENT = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [NUM_W-1:0]   req_segment_start,
   input  logic [PRIME_W-1:0] req_base_prime,
   input  logic [WIDX_W-1:0]  req_word_index,
   output logic               rsp_valid,
   output logic [NUM_W-1:0]   rsp_word_base,
   output logic [WORD_W-1:0]  rsp_prime_flags,
   output logic               rsp_last_word,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [NUM_W-1:0]   csr_upper_bound
);

   localparam int MAP_WORDS = (ODDS_PER_SEGMENT + 63) / 64;
   localparam int IDX_W = ($clog2(ODDS_PER_SEGMENT) > 7) ? $clog2(ODDS_PER_SEGMENT) : 7;
   localparam int WA_W  = IDX_W - 6;
   localparam int CNT_W = ((IDX_W > PRIME_W) ? IDX_W : PRIME_W) + 1;
   localparam int RW    = ((IDX_W + 1 > WIDX_W + 6) ? IDX_W + 1 : WIDX_W + 6) + 1;
   localparam logic [NUM_W:0]  SPAN_MAX    = (NUM_W + 1)'(2 * ODDS_PER_SEGMENT - 2);
   localparam logic [31:0]     MAP_WORDS_U = 32'(MAP_WORDS);
   localparam logic [WA_W-1:0] LAST_WORD   = WA_W'(MAP_WORDS - 1);

   oss_state_type state_ff, state_in;

   logic [NUM_W-1:0]   ub_ff, ub_in;
   logic [NUM_W-1:0]   low_ff, low_in;
   logic [NUM_W-1:0]   high_ff, high_in;
   logic               empty_ff, empty_in;
   logic [IDX_W:0]     nodds_ff, nodds_in;
   logic [WA_W-1:0]    clr_ff, clr_in;
   logic [PRIME_W-1:0] p_ff, p_in;
   logic [NUM_W-1:0]   sq_ff, sq_in;
   logic [PRIME_W-1:0] adj_ff, adj_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               s1_valid_ff, s1_valid_in;
   logic [WA_W-1:0]    s1_addr_ff, s1_addr_in;
   logic [5:0]         s1_bit_ff, s1_bit_in;
   logic               wr_valid_ff, wr_valid_in;
   logic [WA_W-1:0]    wr_addr_ff, wr_addr_in;
   logic [WORD_W-1:0]  wr_data_ff, wr_data_in;
   logic [WIDX_W-1:0]  w_ff, w_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [NUM_W-1:0]   rsp_base_ff, rsp_base_in;
   logic [WORD_W-1:0]  rsp_flags_ff, rsp_flags_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               map_we;
   logic [WA_W-1:0]    map_waddr;
   logic [WORD_W-1:0]  map_wdata;
   logic [WA_W-1:0]    map_raddr;
   logic [WORD_W-1:0]  map_rdata;
   logic               rem_start;
   oss_rem_status_type rem_status;

   logic [NUM_W:0]     span;
   logic [NUM_W:0]     top_end;
   logic [NUM_W-1:0]   start_odd;
   logic [NUM_W-1:0]   sq_diff;
   logic [PRIME_W:0]   adj_odd;
   logic [WA_W+WIDX_W-1:0] word_ext;
   logic               issue;
   logic [WORD_W-1:0]  merge_base;
   logic [RW-1:0]      first_idx;
   logic [RW-1:0]      rem_odds;
   logic               in_range;
   logic [WORD_W-1:0]  tail_mask;

   oss_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (WA_W)
   ) u_map (
      .clock (clock),
      .we    (map_we),
      .waddr (map_waddr),
      .wdata (map_wdata),
      .raddr (map_raddr),
      .rdata (map_rdata)
   );

   oss_rem_unit u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (low_ff),
      .divisor  (p_ff),
      .status   (rem_status)
   );

   // Segment extent, refreshed every cycle from the stored bounds.
   assign span      = {1'b0, high_ff} - {1'b0, low_ff};
   assign top_end   = {1'b0, low_ff} + SPAN_MAX;
   assign start_odd = req_segment_start | NUM_W'(1);
   assign sq_diff   = sq_ff - low_ff;
   assign adj_odd   = adj_ff[0] ? ({1'b0, adj_ff} + {1'b0, p_ff}) : {1'b0, adj_ff};
   assign word_ext  = {{WA_W{1'b0}}, (state_ff == ST_IDLE) ? req_word_index : w_ff};
   assign issue     = idx_ff < CNT_W'(nodds_ff);
   // The previous map write has not reached the word returned by the memory yet.
   assign merge_base = (wr_valid_ff && (wr_addr_ff == s1_addr_ff)) ? wr_data_ff : map_rdata;

   assign first_idx = RW'({w_ff, 6'b0});
   assign rem_odds  = RW'(nodds_ff) - first_idx;
   assign in_range  = !empty_ff && (32'(w_ff) < MAP_WORDS_U) && (first_idx < RW'(nodds_ff));
   assign tail_mask = (rem_odds >= RW'(WORD_W)) ? {WORD_W{1'b1}}
                                                : ~({WORD_W{1'b1}} << rem_odds[5:0]);

   always_comb begin
      state_in     = state_ff;
      ub_in        = csr_valid ? csr_upper_bound : ub_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      empty_in     = span[NUM_W];
      nodds_in     = {1'b0, span[IDX_W:1]} + (IDX_W + 1)'(1);
      clr_in       = clr_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      adj_in       = adj_ff;
      idx_in       = idx_ff;
      s1_valid_in  = 1'b0;
      s1_addr_in   = s1_addr_ff;
      s1_bit_in    = s1_bit_ff;
      wr_valid_in  = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_data_in   = wr_data_ff;
      w_in         = w_ff;
      rsp_valid_in = 1'b0;
      rsp_base_in  = rsp_base_ff;
      rsp_flags_in = rsp_flags_ff;
      rsp_last_in  = rsp_last_ff;
      map_we       = 1'b0;
      map_waddr    = clr_ff;
      map_wdata    = '0;
      map_raddr    = word_ext[WA_W-1:0];
      rem_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  OP_OPEN: begin
                     low_in   = (start_odd < MIN_LOW) ? MIN_LOW : start_odd;
                     state_in = ST_OPEN;
                  end
                  OP_STRIKE: begin
                     // Even values, 1 and an empty segment leave the map as it is.
                     if (req_base_prime[0] && (req_base_prime != PRIME_W'(1)) && !empty_ff) begin
                        p_in     = req_base_prime;
                        state_in = ST_SQ;
                     end
                  end
                  OP_READ: begin
                     w_in     = req_word_index;
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OPEN: begin
            high_in  = (top_end > {1'b0, ub_ff}) ? ub_ff : top_end[NUM_W-1:0];
            clr_in   = '0;
            state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            map_we = 1'b1;
            if (clr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + WA_W'(1);
            end
         end
         ST_SQ: begin
            sq_in    = p_ff * p_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (sq_ff > high_ff) begin
               state_in = ST_IDLE;
            end else if (sq_ff < low_ff) begin
               rem_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               idx_in   = CNT_W'(sq_diff[NUM_W-1:1]);
               state_in = ST_MARK;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               adj_in   = (rem_status.rem == '0) ? '0 : (p_ff - rem_status.rem);
               state_in = ST_ADJ;
            end
         end
         ST_ADJ: begin
            // An odd offset from the odd segment start lands on an even multiple.
            idx_in   = CNT_W'(adj_odd[PRIME_W:1]);
            state_in = ST_MARK;
         end
         ST_MARK: begin
            map_raddr = idx_ff[IDX_W-1:6];
            if (issue) begin
               s1_valid_in = 1'b1;
               s1_addr_in  = idx_ff[IDX_W-1:6];
               s1_bit_in   = idx_ff[5:0];
               idx_in      = idx_ff + CNT_W'(p_ff);
            end
            if (s1_valid_ff) begin
               map_we      = 1'b1;
               map_waddr   = s1_addr_ff;
               map_wdata   = merge_base | (WORD_W'(1) << s1_bit_ff);
               wr_valid_in = 1'b1;
               wr_addr_in  = s1_addr_ff;
               wr_data_in  = map_wdata;
            end
            // The last pending update is written in this same cycle.
            if (!issue) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_base_in  = low_ff + NUM_W'({w_ff, 7'b0});
            rsp_flags_in = in_range ? (~map_rdata & tail_mask) : '0;
            rsp_last_in  = in_range && (rem_odds <= RW'(WORD_W));
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ub_ff        <= {NUM_W{1'b1}};
         low_ff       <= MIN_LOW;
         high_ff      <= '0;
         empty_ff     <= 1'b1;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ub_ff        <= ub_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         empty_ff     <= empty_in;
         clr_ff       <= clr_in;
         s1_valid_ff  <= s1_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nodds_ff     <= nodds_in;
      p_ff         <= p_in;
      sq_ff        <= sq_in;
      adj_ff       <= adj_in;
      idx_ff       <= idx_in;
      s1_addr_ff   <= s1_addr_in;
      s1_bit_ff    <= s1_bit_in;
      wr_addr_ff   <= wr_addr_in;
      wr_data_ff   <= wr_data_in;
      w_ff         <= w_in;
      rsp_base_ff  <= rsp_base_in;
      rsp_flags_ff <= rsp_flags_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word_base   = rsp_base_ff;
   assign rsp_prime_flags = rsp_flags_ff;
   assign rsp_last_word   = rsp_last_ff;

   `ASSERT_CLK(a_rsp_single, rsp_valid_ff |=> !rsp_valid_ff, "result strobe too long")
   `ASSERT_CLK(a_rsp_from_read, rsp_valid_ff |-> $past(state_ff == ST_READ), "result without read")
   `ASSERT_CLK(a_no_write_idle, (state_ff == ST_IDLE || state_ff == ST_READ) |-> !map_we, "bad write")
   `ASSERT_CLK(a_mark_in_map, (map_we && state_ff == ST_MARK) |-> (32'(map_waddr) < MAP_WORDS_U), "bad addr")

endmodule

// File: bench/sieve_flag_checker.sv
// Checker that predicts every prime flag word of the sieve and compares it with the block.
`timescale 1ns / 1ps

module sieve_flag_checker import oss_pkg::*; #(
   parameter int ODDS_PER_SEGMENT = 16384
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [OP_W-1:0]    req_opcode,
   input  logic [NUM_W-1:0]   req_segment_start,
   input  logic [PRIME_W-1:0] req_base_prime,
   input  logic [WIDX_W-1:0]  req_word_index,
   input  logic               rsp_valid,
   input  logic [NUM_W-1:0]   rsp_word_base,
   input  logic [WORD_W-1:0]  rsp_prime_flags,
   input  logic               rsp_last_word,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [NUM_W-1:0]   csr_upper_bound,
   output int                 mismatch_count,
   output int                 words_outstanding
);

   localparam int MAP_WORDS = (ODDS_PER_SEGMENT + 63) / 64;
   localparam int MW_AW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam logic [NUM_W-1:0] BOUND_AT_RESET = '1;

   typedef struct packed {
      logic [NUM_W-1:0]  word_base;
      logic [WORD_W-1:0] prime_flags;
      logic              last_word;
   } flag_word_type;

   logic [WORD_W-1:0] struck_words [MAP_WORDS];
   longint unsigned   seg_low;
   longint unsigned   seg_high;
   longint unsigned   top_bound;
   flag_word_type     expected_words [$];

   function automatic void open_window(input logic [NUM_W-1:0] first_num);
      longint unsigned lo;
      lo = 64'(first_num);
      if (!lo[0]) lo += 1;
      if (lo < 64'(MIN_LOW)) lo = 64'(MIN_LOW);
      seg_low  = lo;
      seg_high = lo + 64'(2 * ODDS_PER_SEGMENT - 2);
      if (seg_high > top_bound) seg_high = top_bound;
      foreach (struck_words[i]) struck_words[i] = '0;
   endfunction

   function automatic void strike_multiples(input longint unsigned p);
      longint unsigned k;
      longint unsigned step;
      longint unsigned idx;
      if (p < 3 || !p[0] || seg_high < seg_low) return;
      k = p * p;
      if (k > seg_high) return;
      // Below the window the walk starts at the first odd multiple inside it.
      if (k < seg_low) begin
         k = ((seg_low + p - 1) / p) * p;
         if (!k[0]) k += p;
      end
      step = 2 * p;
      while (k <= seg_high) begin
         idx = (k - seg_low) >> 1;
         if (idx < ODDS_PER_SEGMENT) struck_words[MW_AW'(idx >> 6)][idx[5:0]] = 1'b1;
         k += step;
      end
   endfunction

   function automatic flag_word_type flag_word_at(input logic [WIDX_W-1:0] w);
      flag_word_type     r;
      longint unsigned   base;
      longint unsigned   n_odds;
      longint unsigned   first_idx;
      longint unsigned   rem;
      logic [WORD_W-1:0] mask;
      base          = seg_low + 64'(w) * 128;
      r.word_base   = base[NUM_W-1:0];
      r.prime_flags = '0;
      r.last_word   = 1'b0;
      if (seg_high >= seg_low && w < MAP_WORDS) begin
         n_odds    = ((seg_high - seg_low) >> 1) + 1;
         first_idx = 64'(w) * 64;
         if (first_idx < n_odds) begin
            rem           = n_odds - first_idx;
            mask          = (rem >= 64) ? '1 : ((64'd1 << rem) - 64'd1);
            r.prime_flags = ~struck_words[MW_AW'(w)] & mask;
            r.last_word   = (rem <= 64);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      flag_word_type want;
      if (reset) begin
         top_bound = 64'(BOUND_AT_RESET);
         seg_low   = 64'(MIN_LOW);
         seg_high  = '0;
         foreach (struck_words[i]) struck_words[i] = '0;
         expected_words.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               $error("flag word at base %h arrived with none expected", rsp_word_base);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_word_base !== want.word_base) begin
                  $error("word_base: expected %h, actual %h", want.word_base, rsp_word_base);
                  mismatch_count++;
               end
               if (rsp_prime_flags !== want.prime_flags) begin
                  $error("prime_flags: expected %h, actual %h",
                         want.prime_flags, rsp_prime_flags);
                  mismatch_count++;
               end
               if (rsp_last_word !== want.last_word) begin
                  $error("last_word: expected %b, actual %b", want.last_word, rsp_last_word);
                  mismatch_count++;
               end
            end
         end
         if (csr_valid && csr_ready) top_bound = 64'(csr_upper_bound);
         if (start && !busy) begin
            case (req_opcode)
               OP_OPEN:   open_window(req_segment_start);
               OP_STRIKE: strike_multiples(64'(req_base_prime));
               OP_READ:   expected_words = {expected_words, flag_word_at(req_word_index)};
               default:   ;
            endcase
         end
      end
      words_outstanding <= expected_words.size();
   end

endmodule

// File: bench/tb.sv
// Testbench top for the odd-only segmented prime sieve: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
   import oss_pkg::*;

   localparam int ODDS_PER_SEGMENT = 16384;
   localparam int WATCHDOG_LIMIT   = 40000;
   localparam int ITEM_TARGET      = 400;
   localparam int QUIET_FROM       = 340;
   localparam int PHASE_ITEMS      = 80;
   localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
   localparam logic [NUM_W-1:0] BOUND_MAX = '1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [OP_W-1:0]    req_opcode = OP_OPEN;
   logic [NUM_W-1:0]   req_segment_start = '0;
   logic [PRIME_W-1:0] req_base_prime = '0;
   logic [WIDX_W-1:0]  req_word_index = '0;
   logic               rsp_valid;
   logic [NUM_W-1:0]   rsp_word_base;
   logic [WORD_W-1:0]  rsp_prime_flags;
   logic               rsp_last_word;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [NUM_W-1:0]   csr_upper_bound = '0;

   int               mismatch_count;
   int               words_outstanding;
   int               items_sent = 0;
   int               idle_cycles = 0;
   bit               gaps_on = 1'b1;
   logic [NUM_W-1:0] bound_now = BOUND_MAX;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   odd_only_segmented_prime_sieve_top #(
      .ODDS_PER_SEGMENT(ODDS_PER_SEGMENT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_segment_start(req_segment_start),
      .req_base_prime(req_base_prime),
      .req_word_index(req_word_index),
      .rsp_valid(rsp_valid),
      .rsp_word_base(rsp_word_base),
      .rsp_prime_flags(rsp_prime_flags),
      .rsp_last_word(rsp_last_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_upper_bound(csr_upper_bound)
   );

   sieve_flag_checker #(
      .ODDS_PER_SEGMENT(ODDS_PER_SEGMENT)
   ) flag_check (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_segment_start(req_segment_start),
      .req_base_prime(req_base_prime),
      .req_word_index(req_word_index),
      .rsp_valid(rsp_valid),
      .rsp_word_base(rsp_word_base),
      .rsp_prime_flags(rsp_prime_flags),
      .rsp_last_word(rsp_last_word),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_upper_bound(csr_upper_bound),
      .mismatch_count(mismatch_count),
      .words_outstanding(words_outstanding)
   );

   // Any transfer on any channel restarts the watchdog.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Presents one command and returns at the edge of its transfer, start still high.
   task automatic issue(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] seg_start,
                        input logic [PRIME_W-1:0] prime, input logic [WIDX_W-1:0] idx);
      int gap;
      gap = 0;
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      if (gaps_on && items_sent < QUIET_FROM && $urandom_range(0, 2) == 0)
         gap = $urandom_range(1, 17);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_opcode        <= op;
      req_segment_start <= seg_start;
      req_base_prime    <= prime;
      req_word_index    <= idx;
      do @(posedge clock); while (busy);
      if (op != OP_UNUSED) items_sent++;
   endtask

   // Drops start and waits until the block is idle and every flag word has come back.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (busy || words_outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_bound(input logic [NUM_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_upper_bound <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      bound_now = value;
   endtask

   // Opens a segment, strikes the odd primes up to its square root (or prime_cap),
   // then reads back a few words, mostly ones that lie inside the segment.
   task automatic sieve_segment(input logic [NUM_W-1:0] seg_start, input int prime_cap,
                                input int reads);
      longint unsigned lo;
      longint unsigned hi;
      int              span;
      int              p;
      int              d;
      bit              is_p;
      lo = 64'(seg_start);
      if (!lo[0]) lo += 1;
      if (lo < 64'(MIN_LOW)) lo = 64'(MIN_LOW);
      hi = lo + 64'(2 * ODDS_PER_SEGMENT - 2);
      if (hi > 64'(bound_now)) hi = 64'(bound_now);
      span = (hi >= lo) ? int'((hi - lo) >> 7) + 1 : 1;
      issue(OP_OPEN, seg_start, PRIME_W'($urandom), WIDX_W'($urandom));
      for (p = 3; p <= prime_cap && longint'(p) * p <= hi; p += 2) begin
         is_p = 1'b1;
         for (d = 3; d * d <= p; d += 2) if (p % d == 0) is_p = 1'b0;
         if (is_p)
            issue(OP_STRIKE, NUM_W'({$urandom, $urandom}), PRIME_W'(p), WIDX_W'($urandom));
      end
      repeat (reads) begin
         if ($urandom_range(0, 7) == 0)
            issue(OP_READ, NUM_W'({$urandom, $urandom}), PRIME_W'($urandom),
                  WIDX_W'($urandom_range(0, 255)));
         else
            issue(OP_READ, NUM_W'({$urandom, $urandom}), PRIME_W'($urandom),
                  WIDX_W'($urandom_range(0, span - 1)));
      end
   endtask

   initial begin
      logic [NUM_W-1:0] wide;
      int               next_phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Nothing opened yet: the segment is empty.
      issue(OP_READ, '0, '0, 8'd0);
      issue(OP_STRIKE, '0, 24'd3, '0);
      issue(OP_UNUSED, BOUND_MAX, '1, '1);
      issue(OP_OPEN, 48'd0, '0, '0);
      // Even and tiny base primes are ignored, and the largest one squares past the end.
      issue(OP_STRIKE, '0, 24'd2, '0);
      issue(OP_STRIKE, '0, 24'd1, '0);
      issue(OP_STRIKE, '0, 24'd0, '0);
      issue(OP_STRIKE, '0, 24'd3, '0);
      issue(OP_STRIKE, '0, 24'd5, '0);
      issue(OP_STRIKE, '0, 24'd7, '0);
      issue(OP_STRIKE, '0, '1, '0);
      issue(OP_READ, '0, '0, 8'd0);
      issue(OP_READ, '0, '0, 8'd255);
      issue(OP_READ, '0, '0, 8'd127);
      // A one-number segment at the top of the range; word one wraps its base.
      issue(OP_OPEN, BOUND_MAX, '0, '0);
      issue(OP_READ, '0, '0, 8'd0);
      issue(OP_READ, '0, '0, 8'd1);
      issue(OP_STRIKE, '0, 24'd3, '0);
      issue(OP_READ, '0, '0, 8'd0);
      settle();
      // A bound below the smallest odd start leaves every segment empty.
      write_bound('0);
      issue(OP_OPEN, 48'd1, '0, '0);
      issue(OP_STRIKE, '0, 24'd3, '0);
      issue(OP_READ, '0, '0, 8'd0);
      settle();
      write_bound(48'd3);
      issue(OP_OPEN, 48'd2, '0, '0);
      issue(OP_READ, '0, '0, 8'd0);
      settle();
      write_bound(BOUND_MAX);

      next_phase = items_sent + PHASE_ITEMS;
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= next_phase) begin
            settle();
            case ($urandom_range(0, 4))
               0:       wide = BOUND_MAX;
               1:       wide = NUM_W'($urandom_range(3, 40000));
               2:       wide = NUM_W'($urandom_range(3000, 12000));
               3:       wide = NUM_W'({$urandom, $urandom});
               default: wide = BOUND_MAX - NUM_W'($urandom_range(0, 20000));
            endcase
            write_bound(wide);
            next_phase += PHASE_ITEMS;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               repeat ($urandom_range(1, 6)) begin
                  wide = NUM_W'({$urandom, $urandom});
                  if ($urandom_range(0, 1) == 0) wide = NUM_W'($urandom_range(0, 70000));
                  issue(OP_W'($urandom_range(0, 3)), wide,
                        ($urandom_range(0, 1) == 0) ? PRIME_W'($urandom)
                                                    : PRIME_W'($urandom_range(0, 99)),
                        WIDX_W'($urandom));
               end
            end
            3: begin
               wide = NUM_W'({$urandom, $urandom});
               if ($urandom_range(0, 2) == 0)
                  wide = BOUND_MAX - NUM_W'($urandom_range(0, 40000));
               sieve_segment(wide, $urandom_range(3, 60), $urandom_range(2, 6));
            end
            default: sieve_segment(NUM_W'($urandom_range(0, 6000)), 200, $urandom_range(4, 10));
         endcase
      end

      settle();
      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
